// ===== rtl/dd_pkg.sv =====
// Package for the date difference block: pipeline control types, constants, calendar tables.
package dd_pkg;

  localparam int unsigned NumStages = 4;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned NumW   = 22;
  localparam int unsigned DiffW  = 23;

  localparam logic [YearW-1:0] YearMax = 14'd9999;

  // floor(x / 100) = (x * 5243) >> 19, exact for any 14-bit x
  localparam logic [12:0]  Div100Mul   = 13'd5243;
  localparam int unsigned  Div100Shift = 19;
  localparam int unsigned  ProdW       = 27;
  localparam int unsigned  QuotW       = 8;

  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [6:0]  Hundred     = 7'd100;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic signed [DiffW-1:0] DiffMax = 23'sd3652059;

  typedef struct packed {
    logic [NumStages-1:0] en;  // stage load enable
    logic [NumStages-1:0] v;   // stage holds a beat
  } dd_ctrl_t;

  function automatic logic [DayW-1:0] dd_month_len(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] dd_days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/dd_if.sv =====
// Valid/ready channel interfaces for date pairs in and day counts out.
interface dd_in_if
  import dd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [DayW-1:0]   end_day;
  logic [MonthW-1:0] end_month;
  logic [YearW-1:0]  end_year;
  logic              include_end_day;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, include_end_day, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, include_end_day, output ready);
endinterface

interface dd_out_if
  import dd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DiffW-1:0] day_difference;
  logic                    date_error;

  modport source (output valid, day_difference, date_error, input ready);
  modport sink   (input valid, day_difference, date_error, output ready);
endinterface

// ===== rtl/dd_pipe_ctrl.sv =====
// Valid bits and stall-aware load enables for the four pipeline stages.
module dd_pipe_ctrl
  import dd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output dd_ctrl_t ctrl_o
);

  logic [NumStages-1:0] v_q, v_d, en;

  // a stage loads when empty or when its contents move on
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctrl_o.en  = en;
  assign ctrl_o.v   = v_q;

endmodule

// ===== rtl/dd_date_num.sv =====
// Three-stage serial day number and validity check for one date.
module dd_date_num
  import dd_pkg::*;
(
  input  logic              clk_i,
  input  dd_ctrl_t          ctrl_i,
  input  logic [DayW-1:0]   day_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  output logic [NumW-1:0]   num_o,
  output logic              ok_o
);

  // stage 1: year - 1 and both quotients by 100
  logic [ProdW-1:0]  y_prod, p_prod;
  logic [YearW-1:0]  p_1;
  logic [DayW-1:0]   d_q1;
  logic [MonthW-1:0] m_q1;
  logic [YearW-1:0]  y_q1, p_q1;
  logic [QuotW-1:0]  yq_q1, pq_q1;

  assign p_1    = year_i - YearW'(1);
  assign y_prod = ProdW'(year_i) * ProdW'(Div100Mul);
  assign p_prod = ProdW'(p_1) * ProdW'(Div100Mul);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      d_q1  <= day_i;
      m_q1  <= month_i;
      y_q1  <= year_i;
      p_q1  <= p_1;
      yq_q1 <= y_prod[Div100Shift +: QuotW];
      pq_q1 <= p_prod[Div100Shift +: QuotW];
    end
  end

  // stage 2: leap rule, validity, 365 * p and the leap-day correction
  logic [14:0]     yq100;
  logic            cent, leap, ok_2;
  logic [DayW-1:0] len;
  logic [11:0]     corr_2;
  logic [8:0]      moff_2;
  logic [NumW-1:0] p365_q2;
  logic [11:0]     corr_q2;
  logic [8:0]      moff_q2;
  logic            ok_q2;

  always_comb begin
    yq100  = 15'(yq_q1) * 15'(Hundred);
    cent   = (yq100 == 15'(y_q1));
    leap   = ((y_q1[1:0] == 2'd0) && !cent) || (cent && (yq_q1[1:0] == 2'd0));
    len    = dd_month_len(m_q1, leap);
    ok_2   = (y_q1 != '0) && (y_q1 <= YearMax) &&
             (m_q1 inside {[4'd1:MonthDec]}) &&
             (d_q1 != '0) && (d_q1 <= len);
    corr_2 = 12'(p_q1 >> 2) - 12'(pq_q1) + 12'(pq_q1 >> 2);
    moff_2 = dd_days_before(m_q1) + 9'(d_q1) + 9'((m_q1 > MonthFeb) && leap);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      p365_q2 <= NumW'(p_q1) * NumW'(DaysPerYear);
      corr_q2 <= corr_2;
      moff_q2 <= moff_2;
      ok_q2   <= ok_2;
    end
  end

  // stage 3: final sum
  logic [NumW-1:0] num_q3;
  logic            ok_q3;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      num_q3 <= p365_q2 + NumW'(corr_q2) + NumW'(moff_q2);
      ok_q3  <= ok_q2;
    end
  end

  assign num_o = num_q3;
  assign ok_o  = ok_q3;

endmodule

// ===== rtl/dd_diff.sv =====
// Output stage: signed difference, end-day count and error masking.
module dd_diff
  import dd_pkg::*;
(
  input  logic                    clk_i,
  input  dd_ctrl_t                ctrl_i,
  input  logic                    inc_i,
  input  logic [NumW-1:0]         s_num_i,
  input  logic [NumW-1:0]         e_num_i,
  input  logic                    s_ok_i,
  input  logic                    e_ok_i,
  output logic signed [DiffW-1:0] diff_o,
  output logic                    err_o
);

  // include flag rides alongside the day-number stages
  logic [NumStages-2:0] inc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      inc_q[0] <= inc_i;
    end
    for (int k = 1; k < NumStages - 1; k++) begin
      if (ctrl_i.en[k]) begin
        inc_q[k] <= inc_q[k-1];
      end
    end
  end

  logic signed [DiffW-1:0] raw, adj;
  logic                    ok;

  always_comb begin
    ok  = s_ok_i && e_ok_i;
    raw = $signed({1'b0, e_num_i}) - $signed({1'b0, s_num_i});
    // one more day away from zero; equal dates count as non-negative
    if (raw[DiffW-1]) begin
      adj = raw - DiffW'(inc_q[NumStages-2]);
    end else begin
      adj = raw + DiffW'(inc_q[NumStages-2]);
    end
  end

  logic signed [DiffW-1:0] diff_q;
  logic                    err_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[NumStages-1]) begin
      diff_q <= ok ? adj : '0;
      err_q  <= !ok;
    end
  end

  assign diff_o = diff_q;
  assign err_o  = err_q;

endmodule

// ===== rtl/date_difference_in_days_top.sv =====
// Top level of the Gregorian date difference pipeline.
// Takes one start/end date pair per beat and returns the signed day count from
// start to end (Gregorian 400-year leap rule), plus one day away from zero when
// include_end_day is set; equal dates give 0 or +1. A day of 0 or past its
// month's length, a month outside 1..12, or a year outside 1..9999 in either
// date sets date_error and forces day_difference to zero. A new pair is taken
// every cycle unless the pipe is full and stalled; the data pass through four
// register stages: divide-by-100 multipliers, leap rule and 365*year multiply,
// day-number sum, and the signed difference in the output register. Output
// back-pressure holds full stages in place while empty stages still fill;
// in_i.ready drops only when every stage is full and the output is held.
module date_difference_in_days_top
  import dd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  dd_in_if.sink    in_i,
  dd_out_if.source out_o
);

  dd_ctrl_t        ctrl;
  logic [NumW-1:0] s_num, e_num;
  logic            s_ok, e_ok;

  // stage valid bits and load enables
  dd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .ctrl_o      (ctrl)
  );

  // serial day numbers of both dates, three stages each
  dd_date_num u_start (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .day_i   (in_i.start_day),
    .month_i (in_i.start_month),
    .year_i  (in_i.start_year),
    .num_o   (s_num),
    .ok_o    (s_ok)
  );

  dd_date_num u_end (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .day_i   (in_i.end_day),
    .month_i (in_i.end_month),
    .year_i  (in_i.end_year),
    .num_o   (e_num),
    .ok_o    (e_ok)
  );

  // difference and output register
  dd_diff u_diff (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .inc_i   (in_i.include_end_day),
    .s_num_i (s_num),
    .e_num_i (e_num),
    .s_ok_i  (s_ok),
    .e_ok_i  (e_ok),
    .diff_o  (out_o.day_difference),
    .err_o   (out_o.date_error)
  );

  assign out_o.valid = ctrl.v[NumStages-1];

  // an error beat never carries a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.date_error) |-> (out_o.day_difference == '0))
    else $error("error beat with nonzero difference");

  // a good beat stays within the calendar's span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.date_error) |->
      ((out_o.day_difference <= DiffMax) && (out_o.day_difference >= -DiffMax)))
    else $error("difference out of range");

  // a full, stalled pipe must refuse new beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&ctrl.v) && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pipe full and stalled");

  // output valid only appears when the stage before it held a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.v[NumStages-2]))
    else $error("output beat from an empty stage");

endmodule
